FILE: sv/bict_pkg.sv
package bict_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam int CFG_RESET_SIZE = 64;

    // Input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    // Completed contour counter
    localparam int CNT_W = 12;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        HD_EAST  = 2'd0,
        HD_NORTH = 2'd1,
        HD_WEST  = 2'd2,
        HD_SOUTH = 2'd3
    } tr_heading_t;

    typedef enum logic [1:0] {
        PH_SEEK  = 2'd0,
        PH_TRACE = 2'd1,
        PH_CLOSE = 2'd2,
        PH_DONE  = 2'd3
    } tr_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLD_RD,
        ST_BLD_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_STEP_MOVE,
        ST_STEP_RD,
        ST_STEP_TURN,
        ST_FIN_CLOSE,
        ST_FIN_DONE,
        ST_PUSH
    } tr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic restart;
        logic img_wr;
        logic bld_init;
        logic bld_wr;
        logic scan_chk;
        logic step_move;
        logic step_rd;
        logic step_turn;
        logic close_res;
        logic done_res;
        logic out_load;
    } tr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        tr_phase_t phase;
        logic      marks_built;
        logic      area_empty;
        logic      ptr_last;
        logic      mark_hit;
        logic      out_free;
    } tr_sts_t;

endpackage

FILE: sv/bict_ctrl.sv
module bict_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_op,
    output logic              s_ready,
    input  bict_pkg::tr_sts_t sts,
    output bict_pkg::tr_cmd_t cmd
);
    import bict_pkg::*;

    tr_state_t state_reg;
    tr_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence one transaction through load, build, scan, step, close or done, and result hand-off
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_LOAD) begin
                        cmd.img_wr  = 1'b1;
                        cmd.restart = 1'b1;
                    end else begin
                        unique case (sts.phase)
                            PH_SEEK: begin
                                priority if (sts.area_empty) begin
                                    state_next = ST_FIN_DONE;
                                end else if (!sts.marks_built) begin
                                    cmd.bld_init = 1'b1;
                                    state_next   = ST_BLD_RD;
                                end else begin
                                    state_next = ST_SCAN_RD;
                                end
                            end
                            PH_TRACE: state_next = ST_STEP_MOVE;
                            PH_CLOSE: state_next = ST_FIN_CLOSE;
                            PH_DONE:  state_next = ST_FIN_DONE;
                        endcase
                    end
                end
            end
            ST_BLD_RD: begin
                state_next = ST_BLD_WR;
            end
            ST_BLD_WR: begin
                cmd.bld_wr = 1'b1;
                state_next = sts.ptr_last ? ST_SCAN_RD : ST_BLD_RD;
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                cmd.scan_chk = 1'b1;
                priority if (sts.mark_hit) begin
                    state_next = ST_STEP_MOVE;
                end else if (sts.ptr_last) begin
                    state_next = ST_FIN_DONE;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_STEP_MOVE: begin
                cmd.step_move = 1'b1;
                state_next    = ST_STEP_RD;
            end
            ST_STEP_RD: begin
                cmd.step_rd = 1'b1;
                state_next  = ST_STEP_TURN;
            end
            ST_STEP_TURN: begin
                cmd.step_turn = 1'b1;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_FIN_CLOSE: begin
                cmd.close_res = 1'b1;
                state_next    = ST_PUSH;
            end
            ST_FIN_DONE: begin
                cmd.done_res = 1'b1;
                state_next   = ST_PUSH;
            end
            ST_PUSH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/bict_dp.sv
module bict_dp #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    localparam int XW = $clog2(MAX_WIDTH + 1),
    localparam int YW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bict_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bict_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [XW-1:0]                       s_pixel_col,
    input  logic [YW-1:0]                       s_pixel_row,
    input  logic                                s_pixel_black,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [XW-1:0]                       m_corner_x,
    output logic [YW-1:0]                       m_corner_y,
    output logic                                m_contour_last,
    output logic                                m_all_done,
    output logic [bict_pkg::CNT_W-1:0]          m_contour_count,
    input  bict_pkg::tr_cmd_t                   cmd,
    output bict_pkg::tr_sts_t                   sts
);
    import bict_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int AW     = CW + RW;
    localparam int DEPTH  = 1 << AW;
    localparam int CMPX_W = (XW > CFG_DATA_W) ? XW : CFG_DATA_W;
    localparam int CMPY_W = (YW > CFG_DATA_W) ? YW : CFG_DATA_W;
    localparam int RST_W  = (MAX_WIDTH < CFG_RESET_SIZE) ? MAX_WIDTH : CFG_RESET_SIZE;
    localparam int RST_H  = (MAX_HEIGHT < CFG_RESET_SIZE) ? MAX_HEIGHT : CFG_RESET_SIZE;

    // Pixel and start-mark memories
    logic img_mem  [DEPTH];
    logic mark_mem [DEPTH];

    logic [XW-1:0]    eff_w_reg, eff_w_next;
    logic [YW-1:0]    eff_h_reg, eff_h_next;
    tr_phase_t        phase_reg, phase_next;
    logic             built_reg, built_next;
    logic [CNT_W-1:0] count_reg, count_next;
    tr_heading_t      heading_reg, heading_next;
    logic [XW-1:0]    cur_x_reg, cur_x_next;
    logic [YW-1:0]    cur_y_reg, cur_y_next;
    logic [XW-1:0]    start_x_reg;
    logic [YW-1:0]    start_y_reg;
    logic [CW-1:0]    ptr_x_reg;
    logic [RW-1:0]    ptr_y_reg;
    logic             l_ok_reg, r_ok_reg;
    logic             img_rd_a_reg, img_rd_b_reg, mark_rd_reg;
    logic [XW-1:0]    res_x_reg;
    logic [YW-1:0]    res_y_reg;
    logic             res_last_reg, res_done_reg;
    logic             out_valid_reg;
    logic [XW-1:0]    out_x_reg;
    logic [YW-1:0]    out_y_reg;
    logic             out_last_reg, out_done_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic [CMPX_W-1:0] cfg_wide_x;
    logic [CMPY_W-1:0] cfg_wide_y;
    logic              restart;
    logic              ptr_last, ptr_row_end;
    logic              load_ok;
    logic [AW-1:0]     img_waddr, img_raddr_a, img_raddr_b;
    logic [AW-1:0]     step_addr_l, step_addr_r, ptr_addr, clr_addr;
    logic              step_ok_l, step_ok_r, clr_ok;
    logic              mark_we, mark_wdata, bld_bit;
    logic [AW-1:0]     mark_waddr;
    logic              xs_ok, xp_ok, ys_ok, yp_ok;
    logic [CW-1:0]     xs_idx, xp_idx;
    logic [RW-1:0]     ys_idx, yp_idx;
    logic              left_blk, right_blk;
    tr_heading_t       heading_turn;

    // Size registers, clamped to the array limits on write
    assign cfg_wide_x = CMPX_W'(cfg_wdata);
    assign cfg_wide_y = CMPY_W'(cfg_wdata);
    always_comb begin
        eff_w_next = eff_w_reg;
        eff_h_next = eff_h_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: eff_w_next = (cfg_wide_x > CMPX_W'(MAX_WIDTH)) ?
                                              XW'(MAX_WIDTH) : XW'(cfg_wide_x);
                REG_IMAGE_HEIGHT: eff_h_next = (cfg_wide_y > CMPY_W'(MAX_HEIGHT)) ?
                                               YW'(MAX_HEIGHT) : YW'(cfg_wide_y);
                default: ;
            endcase
        end
    end

    assign restart = cmd.restart | cfg_wr_en;

    // Raster pointer over the active area
    assign ptr_row_end = (XW'(ptr_x_reg) == eff_w_reg - XW'(1));
    assign ptr_last    = ptr_row_end && (YW'(ptr_y_reg) == eff_h_reg - YW'(1));
    assign ptr_addr    = {ptr_y_reg, ptr_x_reg};

    // Pixel write address for a load
    assign load_ok   = (s_pixel_col != '0) && (s_pixel_col <= XW'(MAX_WIDTH)) &&
                       (s_pixel_row != '0) && (s_pixel_row <= YW'(MAX_HEIGHT));
    assign img_waddr = {RW'(s_pixel_row - YW'(1)), CW'(s_pixel_col - XW'(1))};

    // Neighbour pixels of the cursor: index at or below the corner
    assign xs_ok  = (cur_x_reg != '0) && (cur_x_reg <= eff_w_reg);
    assign xs_idx = CW'(cur_x_reg - XW'(1));
    assign xp_ok  = cur_x_reg < eff_w_reg;
    assign xp_idx = CW'(cur_x_reg);
    assign ys_ok  = (cur_y_reg != '0) && (cur_y_reg <= eff_h_reg);
    assign ys_idx = RW'(cur_y_reg - YW'(1));
    assign yp_ok  = cur_y_reg < eff_h_reg;
    assign yp_idx = RW'(cur_y_reg);

    // Pick the ahead-left and ahead-right pixels for the heading
    always_comb begin
        unique case (heading_reg)
            HD_EAST: begin
                step_addr_l = {ys_idx, xp_idx}; step_ok_l = xp_ok && ys_ok;
                step_addr_r = {yp_idx, xp_idx}; step_ok_r = xp_ok && yp_ok;
            end
            HD_NORTH: begin
                step_addr_l = {ys_idx, xs_idx}; step_ok_l = xs_ok && ys_ok;
                step_addr_r = {ys_idx, xp_idx}; step_ok_r = xp_ok && ys_ok;
            end
            HD_WEST: begin
                step_addr_l = {yp_idx, xs_idx}; step_ok_l = xs_ok && yp_ok;
                step_addr_r = {ys_idx, xs_idx}; step_ok_r = xs_ok && ys_ok;
            end
            HD_SOUTH: begin
                step_addr_l = {yp_idx, xp_idx}; step_ok_l = xp_ok && yp_ok;
                step_addr_r = {yp_idx, xs_idx}; step_ok_r = xs_ok && yp_ok;
            end
        endcase
    end

    assign img_raddr_a = cmd.step_rd ? step_addr_l : {RW'(ptr_y_reg - RW'(1)), ptr_x_reg};
    assign img_raddr_b = cmd.step_rd ? step_addr_r : ptr_addr;

    // Image memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.img_wr && load_ok) begin
            img_mem[img_waddr] <= s_pixel_black;
        end
        img_rd_a_reg <= img_mem[img_raddr_a];
        img_rd_b_reg <= img_mem[img_raddr_b];
    end

    // Mark: black pixel under a white one; clear under the corner on each step
    assign bld_bit    = img_rd_b_reg & ~(img_rd_a_reg & (ptr_y_reg != '0));
    assign clr_ok     = xp_ok && yp_ok;
    assign clr_addr   = {yp_idx, xp_idx};
    assign mark_we    = cmd.bld_wr | (cmd.step_move & clr_ok);
    assign mark_waddr = cmd.step_move ? clr_addr : ptr_addr;
    assign mark_wdata = cmd.step_move ? 1'b0 : bld_bit;

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[ptr_addr];
    end

    // Turn decision from the two neighbour reads
    assign left_blk  = img_rd_a_reg & l_ok_reg;
    assign right_blk = img_rd_b_reg & r_ok_reg;
    always_comb begin
        priority if (left_blk) begin
            heading_turn = tr_heading_t'(heading_reg + 2'd1);
        end else if (!right_blk) begin
            heading_turn = tr_heading_t'(heading_reg - 2'd1);
        end else begin
            heading_turn = heading_reg;
        end
    end

    // Tracer state updates
    always_comb begin
        phase_next   = phase_reg;
        built_next   = built_reg;
        count_next   = count_reg;
        heading_next = heading_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        if (restart) begin
            phase_next   = PH_SEEK;
            built_next   = 1'b0;
            count_next   = '0;
            heading_next = HD_EAST;
        end
        if (cmd.bld_wr && ptr_last) begin
            built_next = 1'b1;
        end
        if (cmd.scan_chk && mark_rd_reg) begin
            phase_next   = PH_TRACE;
            heading_next = HD_EAST;
            cur_x_next   = XW'(ptr_x_reg);
            cur_y_next   = YW'(ptr_y_reg);
        end
        if (cmd.step_move) begin
            unique case (heading_reg)
                HD_EAST:  if (cur_x_reg < XW'(MAX_WIDTH)) cur_x_next = cur_x_reg + XW'(1);
                HD_NORTH: if (cur_y_reg != '0) cur_y_next = cur_y_reg - YW'(1);
                HD_WEST:  if (cur_x_reg != '0) cur_x_next = cur_x_reg - XW'(1);
                HD_SOUTH: if (cur_y_reg < YW'(MAX_HEIGHT)) cur_y_next = cur_y_reg + YW'(1);
            endcase
        end
        if (cmd.step_turn) begin
            heading_next = heading_turn;
            if (cur_x_reg == start_x_reg && cur_y_reg == start_y_reg &&
                heading_turn == HD_EAST) begin
                phase_next = PH_CLOSE;
            end
        end
        if (cmd.close_res) begin
            phase_next = PH_SEEK;
            if (count_reg != CNT_MAX) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.done_res) begin
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg   <= XW'(RST_W);
            eff_h_reg   <= YW'(RST_H);
            phase_reg   <= PH_SEEK;
            built_reg   <= 1'b0;
            count_reg   <= '0;
            heading_reg <= HD_EAST;
        end else begin
            eff_w_reg   <= eff_w_next;
            eff_h_reg   <= eff_h_next;
            phase_reg   <= phase_next;
            built_reg   <= built_next;
            count_reg   <= count_next;
            heading_reg <= heading_next;
        end
    end

    // Cursor, start point, pointer and neighbour flags
    always_ff @(posedge aclk) begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        if (cmd.scan_chk && mark_rd_reg) begin
            start_x_reg <= XW'(ptr_x_reg);
            start_y_reg <= YW'(ptr_y_reg);
        end
        priority if (cmd.bld_init || (cmd.bld_wr && ptr_last)) begin
            ptr_x_reg <= '0;
            ptr_y_reg <= '0;
        end else if (cmd.bld_wr || (cmd.scan_chk && !mark_rd_reg && !ptr_last)) begin
            if (ptr_row_end) begin
                ptr_x_reg <= '0;
                ptr_y_reg <= ptr_y_reg + RW'(1);
            end else begin
                ptr_x_reg <= ptr_x_reg + CW'(1);
            end
        end else begin
            ptr_x_reg <= ptr_x_reg;
        end
        if (cmd.step_rd) begin
            l_ok_reg <= step_ok_l;
            r_ok_reg <= step_ok_r;
        end
    end

    // Result fields of the current transaction
    always_ff @(posedge aclk) begin
        priority if (cmd.step_move || cmd.close_res) begin
            res_x_reg    <= cur_x_reg;
            res_y_reg    <= cur_y_reg;
            res_last_reg <= cmd.close_res;
            res_done_reg <= 1'b0;
        end else if (cmd.done_res) begin
            res_x_reg    <= '0;
            res_y_reg    <= '0;
            res_last_reg <= 1'b0;
            res_done_reg <= 1'b1;
        end else begin
            res_x_reg <= res_x_reg;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_x_reg     <= res_x_reg;
            out_y_reg     <= res_y_reg;
            out_last_reg  <= res_last_reg;
            out_done_reg  <= res_done_reg;
            out_count_reg <= count_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_corner_x      = out_x_reg;
    assign m_corner_y      = out_y_reg;
    assign m_contour_last  = out_last_reg;
    assign m_all_done      = out_done_reg;
    assign m_contour_count = out_count_reg;

    // Status back to the controller
    assign sts.phase       = phase_reg;
    assign sts.marks_built = built_reg;
    assign sts.area_empty  = (eff_w_reg == '0) || (eff_h_reg == '0);
    assign sts.ptr_last    = ptr_last;
    assign sts.mark_hit    = mark_rd_reg;
    assign sts.out_free    = !out_valid_reg || m_ready;

endmodule

FILE: sv/binary_image_contour_tracer_top.sv
// Load transaction: no result; it restarts the tracer.
// Contour point: the move, two-read neighbour step and turn states, then the result hand-off.
// Closing point or no-contour answer: a close or done state, then the push state.
// First request after a restart: a read and a write state per active pixel to build start marks,
// then a read and a check state per pixel visited by the start scan, which resumes where it stopped.
// Reset (synchronous, active low): sizes 64 clamped to the array, tracer seeking.
module binary_image_contour_tracer_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    localparam int XW = $clog2(MAX_WIDTH + 1),
    localparam int YW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bict_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bict_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [XW-1:0]                   s_pixel_col,
    input  logic [YW-1:0]                   s_pixel_row,
    input  logic                            s_pixel_black,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [XW-1:0]                   m_corner_x,
    output logic [YW-1:0]                   m_corner_y,
    output logic                            m_contour_last,
    output logic                            m_all_done,
    output logic [bict_pkg::CNT_W-1:0]      m_contour_count
);
    import bict_pkg::*;

    tr_cmd_t cmd;
    tr_sts_t sts;

    // Sequencer
    bict_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Memories, tracer registers and output register
    bict_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_pixel_col     (s_pixel_col),
        .s_pixel_row     (s_pixel_row),
        .s_pixel_black   (s_pixel_black),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_corner_x      (m_corner_x),
        .m_corner_y      (m_corner_y),
        .m_contour_last  (m_contour_last),
        .m_all_done      (m_all_done),
        .m_contour_count (m_contour_count),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

FILE: sv/bict_checker.sv
module bict_checker #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    localparam int XW = $clog2(MAX_WIDTH + 1),
    localparam int YW = $clog2(MAX_HEIGHT + 1)
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_wr_en,
    input logic [bict_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [bict_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_op,
    input logic [XW-1:0]                   s_pixel_col,
    input logic [YW-1:0]                   s_pixel_row,
    input logic                            s_pixel_black,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [XW-1:0]                   m_corner_x,
    input logic [YW-1:0]                   m_corner_y,
    input logic                            m_contour_last,
    input logic                            m_all_done,
    input logic [bict_pkg::CNT_W-1:0]      m_contour_count
);
    import bict_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_corner_x) && $stable(m_corner_y) &&
        $stable(m_contour_last) && $stable(m_all_done) && $stable(m_contour_count))
        else $error("result changed while stalled");

    // No-contour answer carries a zero point
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_all_done |-> !m_contour_last && m_corner_x == '0 && m_corner_y == '0)
        else $error("no-contour answer with point data");

    // A closing point counts its own contour
    a_close_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_contour_last |-> !m_all_done && m_contour_count != '0)
        else $error("closing point without a counted contour");

    // A load on an empty output produces no result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_LOAD && !m_valid |=> !m_valid)
        else $error("result after a pixel load");

endmodule

bind binary_image_contour_tracer_top bict_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_bict_checker (.*);
